// ----- rtl/csft_pkg.sv -----
// ----------------------------------------------------------------------------
// Chi-square fit test package
// Shared widths, constants and the command and status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package csft_pkg;

  // Field widths of the stream items.
  localparam int CountW = 32;
  localparam int ExpW   = 32;
  localparam int StatW  = 48;

  // Result beat is padded to whole bytes.
  localparam int OutDataW = 56;

  // Default pass threshold, about 16.919 in Q32.16.
  localparam logic [StatW-1:0] CritReset = 48'd1108804;
  localparam logic [StatW-1:0] StatMax   = {StatW{1'b1}};

  // Sequencing of one bin: four multiply steps, then one quotient bit per step.
  localparam int MulSteps = 4;
  localparam int DivSteps = 48;
  localparam int CntW     = 6;

  // Multiply step codes.
  localparam logic [1:0] MulLoLo = 2'd0;
  localparam logic [1:0] MulLoHi = 2'd1;
  localparam logic [1:0] MulHiHi = 2'd2;
  localparam logic [1:0] MulLast = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       sat_chk;
    logic       div_en;
    logic       accum;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_stall;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/chi_square_fit_test_unit.sv -----
// ----------------------------------------------------------------------------
// Chi-square fit test unit
// Streams histogram bins and reports the chi-square goodness-of-fit statistic.
// ----------------------------------------------------------------------------
// Each input beat is one histogram bin: an observed count and an expected
// value in unsigned Q16.16. The unit adds (observed - expected)^2 / expected
// for every bin with a nonzero expected value to a saturating Q32.16 sum; on
// the beat with in_tlast set it returns one result beat with the statistic,
// a pass flag (statistic at or below the critical value, no error) and a
// flag for runs longer than BINS bins, then starts a new run. A bin goes
// from accept through a load step, the shared 32 by 32 multiplier that squares
// the deviation, a check step, the radix-2 divider that makes one quotient bit
// a cycle and an accumulate step before the next bin is accepted. A final bin
// can hold in its accumulate step while an earlier result beat is still not taken.
// The critical value, reset 16.919, is written on the cfg channel, which is
// always ready; the user is to write it while the unit idles (not enforced).
`default_nettype none

module chi_square_fit_test_unit
  import csft_pkg::*;
#(
  parameter int BINS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Bin input: [31:0] observed_count, [63:32] expected_value.
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [63:0]         in_tdata,
  input  wire logic                in_tlast,
  // Result: [47:0] statistic, [48] good_fit, [49] too_many_bins, [55:50] zero.
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,
  // Critical value write, unsigned Q32.16.
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [StatW-1:0]    cfg_data
);

  cmd_t             cmd;
  status_t          status;
  logic [StatW-1:0] res_stat;
  logic             res_good;
  logic             res_tmb;

  csft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  csft_datapath #(
    .BINS (BINS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .observed_count    (in_tdata[31:0]),
    .expected_value    (in_tdata[63:32]),
    .last_bin          (in_tlast),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_statistic     (res_stat),
    .out_good_fit      (res_good),
    .out_too_many_bins (res_tmb)
  );

  // Pack the result beat and keep the configuration channel open.
  always_comb begin
    out_tdata = {6'b0, res_tmb, res_good, res_stat};
    cfg_ready = 1'b1;
  end

endmodule

`default_nettype wire

// ----- rtl/csft_ctrl.sv -----
// ----------------------------------------------------------------------------
// Chi-square fit test controller
// Sequences one bin through load, squaring, saturation check, long
// division and accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module csft_ctrl
  import csft_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StAcc  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.mul_step = cnt_r[1:0];
    unique case (state_r)
      StIdle: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = StMul;
        end
      end
      StMul: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CntW'(MulSteps - 1)) begin
          state_nxt = StChk;
        end
      end
      StChk: begin
        cmd.sat_chk = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = StDiv;
      end
      StDiv: begin
        cmd.div_en = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CntW'(DivSteps - 1)) begin
          state_nxt = StAcc;
        end
      end
      StAcc: begin
        // A final bin waits until the output register is free.
        if (!status.out_stall) begin
          cmd.accum = 1'b1;
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/csft_datapath.sv -----
// ----------------------------------------------------------------------------
// Chi-square fit test datapath
// Holds the bin operands, squares the deviation with one shared multiplier,
// divides by the expected value one quotient bit per step and keeps the
// saturating run sum, bin count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csft_datapath
  import csft_pkg::*;
#(
  parameter int BINS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output status_t                  status,
  input  wire logic [CountW-1:0]   observed_count,
  input  wire logic [ExpW-1:0]     expected_value,
  input  wire logic                last_bin,
  input  wire logic                cfg_we,
  input  wire logic [StatW-1:0]    cfg_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [StatW-1:0]         out_statistic,
  output logic                     out_good_fit,
  output logic                     out_too_many_bins
);

  localparam int BinW = $clog2(BINS + 1);

  // Operand and arithmetic registers.
  logic [ExpW-1:0]  exp_r;
  logic             last_r;
  logic [StatW-1:0] dev_r;
  logic [63:0]      prod_r;
  logic [95:0]      sq_r;
  logic             sat_r;
  logic [ExpW-1:0]  rem_r;
  logic [StatW-1:0] low_r;
  logic [StatW-1:0] quo_r;

  // Run state and result registers.
  logic [StatW-1:0] crit_r;
  logic [StatW-1:0] sum_r;
  logic [BinW-1:0]  bins_r;
  logic             ovf_r;
  logic             out_valid_r;
  logic [StatW-1:0] out_stat_r;
  logic             out_good_r;
  logic             out_tmb_r;

  // Absolute deviation of the observed count from the expected value.
  logic [StatW-1:0] obs_fix;
  logic [StatW-1:0] exp_fix;
  logic [StatW-1:0] dev_nxt;

  always_comb begin
    obs_fix = {observed_count, 16'b0};
    exp_fix = {16'b0, expected_value};
    dev_nxt = (obs_fix >= exp_fix) ? (obs_fix - exp_fix) : (exp_fix - obs_fix);
  end

  // Shared 32 by 32 multiplier over the halves of the deviation.
  logic [31:0] dev_lo;
  logic [31:0] dev_hi;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod_nxt;
  logic [95:0] sq_nxt;

  always_comb begin
    dev_lo   = dev_r[31:0];
    dev_hi   = {16'b0, dev_r[47:32]};
    mul_a    = (cmd.mul_step == MulHiHi) ? dev_hi : dev_lo;
    mul_b    = (cmd.mul_step == MulLoLo) ? dev_lo : dev_hi;
    prod_nxt = mul_a * mul_b;
    // The first step clears the square; each later step adds the product registered in the step before.
    unique case (cmd.mul_step)
      MulLoLo: sq_nxt = '0;
      MulLoHi: sq_nxt = {32'b0, prod_r};
      MulHiHi: sq_nxt = sq_r + {15'b0, prod_r[47:0], 33'b0};
      MulLast: sq_nxt = sq_r + {prod_r[31:0], 64'b0};
      default: sq_nxt = sq_r;
    endcase
  end

  // One restoring division step.
  logic [32:0] trial;
  logic [32:0] trial_diff;
  logic        q_bit;

  always_comb begin
    trial      = {rem_r, low_r[StatW-1]};
    trial_diff = trial - {1'b0, exp_r};
    q_bit      = (trial >= {1'b0, exp_r});
  end

  // Bin term, saturating sum and bin count.
  logic [StatW-1:0] term;
  logic [StatW:0]   sum_wide;
  logic [StatW-1:0] sum_new;
  logic             bins_full;
  logic             ovf_new;
  logic [BinW-1:0]  bins_new;

  always_comb begin
    if (exp_r == '0) begin
      term = '0;
    end else if (sat_r) begin
      term = StatMax;
    end else begin
      term = quo_r;
    end
    sum_wide  = {1'b0, sum_r} + {1'b0, term};
    sum_new   = sum_wide[StatW] ? StatMax : sum_wide[StatW-1:0];
    bins_full = (bins_r >= BinW'(BINS));
    ovf_new   = ovf_r | bins_full;
    bins_new  = bins_full ? bins_r : (bins_r + 1'b1);
  end

  // Operand and arithmetic registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_r  <= expected_value;
      last_r <= last_bin;
      dev_r  <= dev_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
      sq_r   <= sq_nxt;
    end
    if (cmd.sat_chk) begin
      // The quotient fits 48 bits exactly when the upper square is below e.
      sat_r <= (sq_r[95:48] >= {16'b0, exp_r});
      rem_r <= sq_r[79:48];
      low_r <= sq_r[47:0];
      quo_r <= '0;
    end
    if (cmd.div_en) begin
      rem_r <= q_bit ? trial_diff[31:0] : trial[31:0];
      low_r <= {low_r[StatW-2:0], 1'b0};
      quo_r <= {quo_r[StatW-2:0], q_bit};
    end
    if (cmd.accum && last_r) begin
      out_stat_r <= sum_new;
      out_good_r <= !ovf_new && (sum_new <= crit_r);
      out_tmb_r  <= ovf_new;
    end
  end

  // Control state: threshold, run state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_r      <= CritReset;
      sum_r       <= '0;
      bins_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        crit_r <= cfg_data;
      end
      if (cmd.accum) begin
        if (last_r) begin
          sum_r  <= '0;
          bins_r <= '0;
          ovf_r  <= 1'b0;
        end else begin
          sum_r  <= sum_new;
          bins_r <= bins_new;
          ovf_r  <= ovf_new;
        end
      end
      if (cmd.accum && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    status.out_stall  = last_r && out_valid_r && !out_ready;
    out_valid         = out_valid_r;
    out_statistic     = out_stat_r;
    out_good_fit      = out_good_r;
    out_too_many_bins = out_tmb_r;
  end

endmodule

`default_nettype wire
